FILE: rtl/core/bsa_pkg.sv
package bsa_pkg;

    localparam int SLOTS_PER_BLOCK_DEF = 32;
    localparam int MAX_BLOCKS_DEF      = 8;

    localparam int ADDR_W     = 48;
    localparam int BASE_W     = 32;
    localparam int ESIZE_W    = 16;
    localparam int BLK_OUT_W  = 4;
    localparam int SLOT_OUT_W = 6;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 64;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_POOL_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_SIZE  = 8'd1;

    typedef struct packed {
        logic start;
        logic scan_dec;
        logic pick_old;
        logic pick_new;
        logic mul_alloc;
        logic mul_free;
        logic alloc_commit;
        logic set_full;
        logic set_notfound;
        logic div_init;
        logic div_step;
        logic blk_step;
        logic free_commit;
        logic out_load;
    } bsa_cmd_t;

    typedef struct packed {
        logic cur_zero;
        logic cur_map_full;
        logic created_max;
        logic free_miss;
        logic div_last;
        logic q_ge_spb;
        logic out_busy;
    } bsa_sts_t;

endpackage

FILE: rtl/core/bsa_ctrl.sv
module bsa_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tuser,
    output logic               s_tready,
    input  bsa_pkg::bsa_sts_t  sts,
    output bsa_pkg::bsa_cmd_t  cmd
);
    import bsa_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ASCAN   = 4'd1;
    localparam logic [3:0] S_AMUL    = 4'd2;
    localparam logic [3:0] S_ACOMMIT = 4'd3;
    localparam logic [3:0] S_FMUL    = 4'd4;
    localparam logic [3:0] S_FCHK    = 4'd5;
    localparam logic [3:0] S_FDIV    = 4'd6;
    localparam logic [3:0] S_FBLK    = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.start  = 1'b1;
                    state_next = (s_tuser == OP_FREE) ? S_FMUL : S_ASCAN;
                end
            end
            S_ASCAN: begin
                if (sts.cur_zero) begin
                    if (sts.created_max) begin
                        cmd.set_full = 1'b1;
                        state_next   = S_DONE;
                    end else begin
                        cmd.pick_new = 1'b1;
                        state_next   = S_AMUL;
                    end
                end else if (!sts.cur_map_full) begin
                    cmd.pick_old = 1'b1;
                    state_next   = S_AMUL;
                end else begin
                    cmd.scan_dec = 1'b1;
                end
            end
            S_AMUL: begin
                cmd.mul_alloc = 1'b1;
                state_next    = S_ACOMMIT;
            end
            S_ACOMMIT: begin
                cmd.alloc_commit = 1'b1;
                state_next       = S_DONE;
            end
            S_FMUL: begin
                cmd.mul_free = 1'b1;
                state_next   = S_FCHK;
            end
            S_FCHK: begin
                if (sts.free_miss) begin
                    cmd.set_notfound = 1'b1;
                    state_next       = S_DONE;
                end else begin
                    cmd.div_init = 1'b1;
                    state_next   = S_FDIV;
                end
            end
            S_FDIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = S_FBLK;
                end
            end
            S_FBLK: begin
                if (sts.q_ge_spb) begin
                    cmd.blk_step = 1'b1;
                end else begin
                    cmd.free_commit = 1'b1;
                    state_next      = S_DONE;
                end
            end
            S_DONE: begin
                if (!sts.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/bsa_datapath.sv
module bsa_datapath #(
    parameter int SLOTS_PER_BLOCK = bsa_pkg::SLOTS_PER_BLOCK_DEF,
    parameter int MAX_BLOCKS      = bsa_pkg::MAX_BLOCKS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  bsa_pkg::bsa_cmd_t               cmd,
    output bsa_pkg::bsa_sts_t               sts,
    input  logic [bsa_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            cfg_valid,
    input  logic [bsa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bsa_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            m_tready,
    output logic                            m_tvalid,
    output logic [bsa_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [bsa_pkg::STAT_W-1:0]      m_tuser
);
    import bsa_pkg::*;

    localparam int SL_W   = $clog2(SLOTS_PER_BLOCK);
    localparam int BI_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W  = $clog2(MAX_BLOCKS * SLOTS_PER_BLOCK + 1);
    localparam int PROD_W = IDX_W + ESIZE_W;
    localparam int J_W    = $clog2(IDX_W);

    localparam logic [SLOTS_PER_BLOCK-1:0] FULL_MAP = '1;
    localparam logic [IDX_W-1:0]           SPB_IDX  = IDX_W'(SLOTS_PER_BLOCK);
    localparam logic [CNT_W-1:0]           MAX_CNT  = CNT_W'(MAX_BLOCKS);

    logic [BASE_W-1:0]          base_reg;
    logic [ESIZE_W-1:0]         esize_reg;
    logic [SLOTS_PER_BLOCK-1:0] maps_reg [MAX_BLOCKS];
    logic [CNT_W-1:0]           created_reg;
    logic [CNT_W-1:0]           cur_reg;
    logic [BI_W-1:0]            target_reg;
    logic [SL_W-1:0]            slot_reg;
    logic                       newblk_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic [ADDR_W-1:0]          off_reg;
    logic                       below_reg;
    logic [PROD_W-1:0]          rem_reg;
    logic [IDX_W-1:0]           q_reg;
    logic [J_W-1:0]             j_reg;
    logic [BI_W-1:0]            blk_reg;
    logic [ADDR_W-1:0]          res_addr_reg;
    logic [BI_W-1:0]            res_blk_reg;
    logic [SL_W-1:0]            res_slot_reg;
    logic [STAT_W-1:0]          res_status_reg;
    logic                       m_tvalid_reg;
    logic [M_TDATA_W-1:0]       m_tdata_reg;
    logic [STAT_W-1:0]          m_tuser_reg;

    logic [CNT_W-1:0]           cur_dec;
    logic [BI_W-1:0]            cur_idx;
    logic [SLOTS_PER_BLOCK-1:0] cur_map;
    logic [SL_W-1:0]            free_slot;
    logic [IDX_W-1:0]           mul_a;
    logic [PROD_W-1:0]          prod_next;
    logic [ADDR_W:0]            diff;
    logic [PROD_W-1:0]          div_shifted;

    function automatic logic [SL_W-1:0] first_zero(input logic [SLOTS_PER_BLOCK-1:0] map);
        logic [SL_W-1:0] pos;
        pos = '0;
        for (int i = SLOTS_PER_BLOCK - 1; i >= 0; i--) begin
            if (!map[i]) begin
                pos = SL_W'(i);
            end
        end
        return pos;
    endfunction

    assign cur_dec   = cur_reg - CNT_W'(1);
    assign cur_idx   = cur_dec[BI_W-1:0];
    assign cur_map   = maps_reg[cur_idx];
    assign free_slot = first_zero(cur_map);

    assign mul_a = cmd.mul_free ? IDX_W'(created_reg) * SPB_IDX
                                : IDX_W'(target_reg) * SPB_IDX + IDX_W'(slot_reg);
    assign prod_next   = PROD_W'(mul_a) * PROD_W'(esize_reg);
    assign diff        = {1'b0, s_tdata[ADDR_W-1:0]} - (ADDR_W + 1)'(base_reg);
    assign div_shifted = PROD_W'(esize_reg) << j_reg;

    assign sts.cur_zero     = (cur_reg == '0);
    assign sts.cur_map_full = (cur_map == FULL_MAP);
    assign sts.created_max  = (created_reg == MAX_CNT);
    assign sts.free_miss    = below_reg || (esize_reg == '0) ||
                              (off_reg >= ADDR_W'(prod_reg));
    assign sts.div_last     = (j_reg == '0);
    assign sts.q_ge_spb     = (q_reg >= SPB_IDX);
    assign sts.out_busy     = m_tvalid_reg && !m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg     <= '0;
            esize_reg    <= ESIZE_W'(1);
            created_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            for (int k = 0; k < MAX_BLOCKS; k++) begin
                maps_reg[k] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_REGION_BASE: base_reg  <= cfg_data[BASE_W-1:0];
                    REG_ENTRY_SIZE:  esize_reg <= cfg_data[ESIZE_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.alloc_commit) begin
                maps_reg[target_reg][slot_reg] <= 1'b1;
                if (newblk_reg) begin
                    created_reg <= created_reg + CNT_W'(1);
                end
            end
            if (cmd.free_commit) begin
                maps_reg[blk_reg][q_reg[SL_W-1:0]] <= 1'b0;
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            cur_reg   <= created_reg;
            off_reg   <= diff[ADDR_W-1:0];
            below_reg <= diff[ADDR_W];
        end
        if (cmd.scan_dec) begin
            cur_reg <= cur_dec;
        end
        if (cmd.pick_old) begin
            target_reg <= cur_idx;
            slot_reg   <= free_slot;
            newblk_reg <= 1'b0;
        end
        if (cmd.pick_new) begin
            target_reg <= created_reg[BI_W-1:0];
            slot_reg   <= '0;
            newblk_reg <= 1'b1;
        end
        if (cmd.mul_alloc || cmd.mul_free) begin
            prod_reg <= prod_next;
        end
        if (cmd.div_init) begin
            rem_reg <= off_reg[PROD_W-1:0];
            q_reg   <= '0;
            j_reg   <= J_W'(IDX_W - 1);
            blk_reg <= '0;
        end
        if (cmd.div_step) begin
            if (rem_reg >= div_shifted) begin
                rem_reg      <= rem_reg - div_shifted;
                q_reg[j_reg] <= 1'b1;
            end
            j_reg <= j_reg - J_W'(1);
        end
        if (cmd.blk_step) begin
            q_reg   <= q_reg - SPB_IDX;
            blk_reg <= blk_reg + BI_W'(1);
        end
        if (cmd.alloc_commit) begin
            res_addr_reg   <= ADDR_W'(base_reg) + ADDR_W'(prod_reg);
            res_blk_reg    <= target_reg;
            res_slot_reg   <= slot_reg;
            res_status_reg <= ST_OK;
        end
        if (cmd.free_commit) begin
            res_addr_reg   <= '0;
            res_blk_reg    <= blk_reg;
            res_slot_reg   <= q_reg[SL_W-1:0];
            res_status_reg <= ST_OK;
        end
        if (cmd.set_full || cmd.set_notfound) begin
            res_addr_reg   <= '0;
            res_blk_reg    <= '0;
            res_slot_reg   <= '0;
            res_status_reg <= cmd.set_full ? ST_POOL_FULL : ST_NOT_FOUND;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= M_TDATA_W'({SLOT_OUT_W'(res_slot_reg), BLK_OUT_W'(res_blk_reg),
                                       res_addr_reg});
            m_tuser_reg <= res_status_reg;
        end
    end

    a_created_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        created_reg <= MAX_CNT)
        else $error("Block count exceeds the number of blocks.");

    a_alloc_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.alloc_commit |-> !maps_reg[target_reg][slot_reg])
        else $error("Allocation picked a slot that is already taken.");

    a_new_block_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.alloc_commit && newblk_reg |=> created_reg == $past(created_reg) + CNT_W'(1))
        else $error("Opening a block did not advance the block count.");

    a_free_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.free_commit |-> (CNT_W'(blk_reg) < created_reg) && (q_reg < SPB_IDX))
        else $error("Free resolved to a slot outside the open blocks.");

endmodule

FILE: rtl/core/bitmap_slot_allocator_top.sv
// Slot allocator over up to MAX_BLOCKS blocks of SLOTS_PER_BLOCK fixed-size slots, one item at
// a time. An allocate item scans the open blocks newest first, one block per cycle, then
// multiplies out the address of the chosen slot and commits it; a full pool answers straight
// from the scan. A free item that misses the open blocks answers without dividing; otherwise
// it divides the offset of its address by entry_size in a restoring divider, one quotient bit
// per cycle over W = clog2(MAX_BLOCKS*SLOTS_PER_BLOCK+1) bits (9 by default), then steps the
// quotient down by whole blocks to find the block hit. A new item is taken while the previous
// result still waits on the result side. Configuration writes are always taken and must only
// happen while the block is idle.
module bitmap_slot_allocator_top #(
    parameter int SLOTS_PER_BLOCK = bsa_pkg::SLOTS_PER_BLOCK_DEF,
    parameter int MAX_BLOCKS      = bsa_pkg::MAX_BLOCKS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bsa_pkg::S_TDATA_W-1:0]   s_tdata,   // [47:0] address
    input  logic                            s_tuser,   // [0] opcode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bsa_pkg::M_TDATA_W-1:0]   m_tdata,   // [47:0] result_address,
                                                       // [51:48] block_index,
                                                       // [57:52] slot_index, [63:58] zero
    output logic [bsa_pkg::STAT_W-1:0]      m_tuser,   // [1:0] status
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bsa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bsa_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bsa_pkg::*;

    bsa_cmd_t cmd;
    bsa_sts_t sts;

    assign cfg_ready = 1'b1;

    bsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bsa_datapath #(
        .SLOTS_PER_BLOCK (SLOTS_PER_BLOCK),
        .MAX_BLOCKS      (MAX_BLOCKS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import bsa_pkg::*;

    localparam int SPB  = SLOTS_PER_BLOCK_DEF;
    localparam int NBLK = MAX_BLOCKS_DEF;

    typedef struct packed {
        logic [ADDR_W-1:0]     addr;
        logic [BLK_OUT_W-1:0]  blk;
        logic [SLOT_OUT_W-1:0] slot;
        logic [STAT_W-1:0]     status;
    } reply_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [STAT_W-1:0]     m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [SPB-1:0]        occ_map [NBLK];
    int                    open_blocks;
    logic [BASE_W-1:0]     pool_base;
    logic [ESIZE_W-1:0]    slot_bytes;

    reply_t                pending_replies[$];
    int                    fail_count;
    int                    src_idle_pct;
    int                    snk_stall_pct;
    int                    stall_request;
    int                    stall_left;

    bitmap_slot_allocator_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [63:0] block_span();
        return 64'(SPB) * 64'(slot_bytes);
    endfunction

    function automatic logic [63:0] block_base(input int k);
        return 64'(pool_base) + 64'(k) * block_span();
    endfunction

    function automatic reply_t predict_alloc();
        reply_t r;
        int     k;
        int     i;
        bit     found;
        r = '0;
        r.status = ST_POOL_FULL;
        found = 1'b0;
        for (k = open_blocks - 1; k >= 0 && !found; k--) begin
            if (occ_map[k] != '1) begin
                for (i = 0; i < SPB && !found; i++) begin
                    if (!occ_map[k][i]) begin
                        occ_map[k][i] = 1'b1;
                        r.addr   = ADDR_W'(block_base(k) + 64'(i) * 64'(slot_bytes));
                        r.blk    = BLK_OUT_W'(k);
                        r.slot   = SLOT_OUT_W'(i);
                        r.status = ST_OK;
                        found    = 1'b1;
                    end
                end
            end
        end
        if (!found && open_blocks < NBLK) begin
            k = open_blocks;
            open_blocks++;
            occ_map[k] = SPB'(1);
            r.addr   = ADDR_W'(block_base(k));
            r.blk    = BLK_OUT_W'(k);
            r.slot   = '0;
            r.status = ST_OK;
        end
        return r;
    endfunction

    function automatic reply_t predict_release(input logic [ADDR_W-1:0] addr);
        reply_t      r;
        int          k;
        logic [63:0] base;
        logic [63:0] off;
        logic [63:0] slot;
        r = '0;
        r.status = ST_NOT_FOUND;
        for (k = open_blocks - 1; k >= 0; k--) begin
            base = block_base(k);
            if (64'(addr) >= base) begin
                off = 64'(addr) - base;
                if (off < block_span() && slot_bytes != 0) begin
                    slot = off / 64'(slot_bytes);
                    if (slot < SPB) begin
                        occ_map[k][slot] = 1'b0;
                        r.blk    = BLK_OUT_W'(k);
                        r.slot   = SLOT_OUT_W'(slot);
                        r.status = ST_OK;
                        return r;
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] pick_release_addr();
        int          r;
        int          k;
        int          i;
        logic [63:0] a;
        r = $urandom_range(99);
        a = {$urandom, $urandom};
        if (r < 75 && open_blocks > 0) begin
            k = $urandom_range(open_blocks - 1);
            i = $urandom_range(SPB - 1);
            if (occ_map[k] != '0) begin
                while (!occ_map[k][i])
                    i = $urandom_range(SPB - 1);
            end
            a = block_base(k) + 64'(i) * 64'(slot_bytes);
            if (slot_bytes > 1)
                a = a + 64'($urandom_range(slot_bytes - 1));
        end else if (r < 88) begin
            case ($urandom_range(3))
                0: a = 64'(pool_base) - 64'd1;
                1: a = block_base(open_blocks);
                2: a = block_base(open_blocks) - 64'd1;
                default: a = 64'(pool_base);
            endcase
        end
        return a[ADDR_W-1:0];
    endfunction

    always @(posedge aclk) begin
        if (stall_request > 0) begin
            stall_left = stall_request;
            stall_request = 0;
        end
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin : check_reply
            reply_t want;
            if (pending_replies.size() == 0) begin
                $error("result with no pending item: tdata=%h tuser=%h", m_tdata, m_tuser);
                fail_count++;
            end else begin
                want = pending_replies.pop_front();
                if (m_tdata[47:0] !== want.addr) begin
                    $error("result_address expected %h actual %h", want.addr, m_tdata[47:0]);
                    fail_count++;
                end
                if (m_tdata[51:48] !== want.blk) begin
                    $error("block_index expected %0d actual %0d", want.blk, m_tdata[51:48]);
                    fail_count++;
                end
                if (m_tdata[57:52] !== want.slot) begin
                    $error("slot_index expected %0d actual %0d", want.slot, m_tdata[57:52]);
                    fail_count++;
                end
                if (m_tuser !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    task automatic wait_drain();
        if (pending_replies.size() != 0) begin
            s_tvalid <= 1'b0;
            while (pending_replies.size() != 0)
                @(posedge aclk);
        end
    endtask

    task automatic send_item(input logic op, input logic [ADDR_W-1:0] addr);
        reply_t r;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= addr;
        do @(posedge aclk); while (!s_tready);
        if (op == OP_ALLOC)
            r = predict_alloc();
        else
            r = predict_release(addr);
        pending_replies.push_back(r);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        wait_drain();
        repeat (30) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_REGION_BASE)
            pool_base = val;
        else if (idx == REG_ENTRY_SIZE)
            slot_bytes = val[ESIZE_W-1:0];
    endtask

    task automatic test_default_geometry();
        send_item(OP_ALLOC, 48'h0);
        send_item(OP_ALLOC, 48'hFFFF_FFFF_FFFF);
        send_item(OP_FREE, 48'h0);
        send_item(OP_ALLOC, 48'h0);
        send_item(OP_FREE, 48'd31);
        send_item(OP_FREE, 48'd32);
        send_item(OP_FREE, 48'hFFFF_FFFF_FFFF);
        send_item(OP_FREE, 48'd1);
    endtask

    task automatic test_extreme_geometry();
        write_reg(REG_REGION_BASE, 32'hFFFF_FFFF);
        write_reg(REG_ENTRY_SIZE, 32'h0000_FFFF);
        write_reg(8'hFF, 32'h0000_0001);
        send_item(OP_FREE, 48'(block_base(0)));
        send_item(OP_ALLOC, 48'h0);
        send_item(OP_FREE, 48'(block_base(0) - 64'd1));
        send_item(OP_FREE, 48'(block_base(1) - 64'd1));
        send_item(OP_FREE, 48'(block_base(open_blocks)));
        send_item(OP_ALLOC, 48'h0);
    endtask

    task automatic test_zero_entry_size();
        write_reg(REG_ENTRY_SIZE, 32'hABCD_0000);
        write_reg(8'd2, 32'h0000_0040);
        send_item(OP_ALLOC, 48'h0);
        send_item(OP_FREE, 48'(pool_base));
        send_item(OP_FREE, 48'h0);
        send_item(OP_ALLOC, 48'h0);
    endtask

    task automatic test_result_backpressure();
        int n;
        write_reg(REG_REGION_BASE, 32'h0000_1000);
        write_reg(REG_ENTRY_SIZE, 32'h0000_0008);
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        stall_request = 400;
        for (n = 0; n < 24; n++)
            send_item($urandom_range(1) ? OP_FREE : OP_ALLOC, pick_release_addr());
        wait_drain();
    endtask

    task automatic test_drain_pause();
        int n;
        for (n = 0; n < 6; n++) begin
            send_item(OP_ALLOC, 48'h0);
            send_item(OP_FREE, pick_release_addr());
            wait_drain();
        end
    endtask

    task automatic reconfigure();
        logic [BASE_W-1:0]  base;
        logic [ESIZE_W-1:0] size;
        case ($urandom_range(3))
            0: base = 32'h0;
            1: base = 32'hFFFF_FFFF;
            default: base = $urandom;
        endcase
        case ($urandom_range(9))
            0: size = 16'hFFFF;
            1: size = 16'd1;
            2: size = 16'($urandom);
            3: size = 16'd0;
            default: size = 16'($urandom_range(16, 1));
        endcase
        write_reg(REG_REGION_BASE, base);
        write_reg(REG_ENTRY_SIZE, {16'($urandom), size});
        if ($urandom_range(2) == 0)
            write_reg(CFG_IDX_W'($urandom_range(255, 2)), $urandom);
    endtask

    task automatic test_random_traffic(input int src, input int snk, input int alloc_pct,
                                       input int count);
        int   n;
        logic op;
        reconfigure();
        src_idle_pct  = src;
        snk_stall_pct = snk;
        for (n = 0; n < count; n++) begin
            if ($urandom_range(49) == 0)
                wait_drain();
            op = ($urandom_range(99) < alloc_pct) ? OP_ALLOC : OP_FREE;
            if (op == OP_ALLOC)
                send_item(op, ADDR_W'({$urandom, $urandom}));
            else
                send_item(op, pick_release_addr());
        end
        wait_drain();
    endtask

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        aresetn       <= 1'b0;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        s_tuser       <= 1'b0;
        m_tready      <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        fail_count    = 0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        stall_request = 0;
        stall_left    = 0;
        pool_base     = '0;
        slot_bytes    = 16'd1;
        open_blocks   = 0;
        for (int k = 0; k < NBLK; k++)
            occ_map[k] = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_geometry();
        test_extreme_geometry();
        test_zero_entry_size();
        test_result_backpressure();
        test_drain_pause();
        test_random_traffic(0, 0, 90, 250);
        test_random_traffic(69, 0, 50, 250);
        test_random_traffic(0, 69, 60, 250);
        test_random_traffic(8, 8, 40, 250);

        wait_drain();
        repeat (60) @(posedge aclk);
        if (fail_count == 0 && pending_replies.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
